/* rtl/rv32i_decode_and_immediate_unit_defines.svh */
// ----------------------------------------------------------------------------
// RV32I decode and immediate unit: assertion macros
// Shared macros for the concurrent checks of the decode unit.
// ----------------------------------------------------------------------------
`ifndef RV32I_DECODE_AND_IMMEDIATE_UNIT_DEFINES_SVH
`define RV32I_DECODE_AND_IMMEDIATE_UNIT_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define RVDI_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The condition must never hold outside of reset.
`define RVDI_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

/* rtl/rvdi_pkg.sv */
// ----------------------------------------------------------------------------
// RV32I decode and immediate unit: package
// Opcodes, control codes and the structs passed between the decode modules.
// ----------------------------------------------------------------------------
package rvdi_pkg;

   localparam int XLEN = 32;

   typedef logic [6:0] opcode_type;

   localparam opcode_type OPC_LOAD   = 7'h03;
   localparam opcode_type OPC_STORE  = 7'h23;
   localparam opcode_type OPC_OP     = 7'h33;
   localparam opcode_type OPC_OPIMM  = 7'h13;
   localparam opcode_type OPC_BRANCH = 7'h63;
   localparam opcode_type OPC_JAL    = 7'h6f;
   localparam opcode_type OPC_JALR   = 7'h67;
   localparam opcode_type OPC_LUI    = 7'h37;
   localparam opcode_type OPC_AUIPC  = 7'h17;

   typedef enum logic [3:0] {
      ALU_AND  = 4'd0,
      ALU_OR   = 4'd1,
      ALU_ADD  = 4'd2,
      ALU_XOR  = 4'd3,
      ALU_SLL  = 4'd4,
      ALU_SRL  = 4'd5,
      ALU_SRA  = 4'd6,
      ALU_SUB  = 4'd7,
      ALU_SLT  = 4'd8,
      ALU_SLTU = 4'd9,
      ALU_PASS = 4'd10
   } alu_func_type;

   typedef enum logic [2:0] {
      BR_NONE = 3'd0,
      BR_BEQ  = 3'd1,
      BR_BNE  = 3'd2,
      BR_BLT  = 3'd3,
      BR_BGE  = 3'd4,
      BR_BLTU = 3'd5,
      BR_BGEU = 3'd6
   } branch_kind_type;

   typedef enum logic [2:0] {
      IMM_NONE = 3'd0,
      IMM_I    = 3'd1,
      IMM_S    = 3'd2,
      IMM_B    = 3'd3,
      IMM_J    = 3'd4,
      IMM_U    = 3'd5
   } imm_sel_type;

   // Control word from the opcode decoder.
   typedef struct packed {
      logic [4:0]      src1_index;
      logic [4:0]      src2_index;
      logic [4:0]      dest_index;
      logic [2:0]      func3_field;
      branch_kind_type branch_kind;
      logic            is_load;
      logic            is_store;
      logic            writes_register;
      logic            uses_immediate;
      alu_func_type    alu_function;
      imm_sel_type     imm_sel;
      logic            pc_relative;
   } ctrl_type;

   // One decoded result as held in the output register.
   typedef struct packed {
      logic [4:0]      src1_index;
      logic [4:0]      src2_index;
      logic [4:0]      dest_index;
      logic [2:0]      func3_field;
      branch_kind_type branch_kind;
      logic            is_load;
      logic            is_store;
      logic            writes_register;
      logic            uses_immediate;
      alu_func_type    alu_function;
      logic [XLEN-1:0] immediate;
      logic [XLEN-1:0] branch_target;
   } result_type;

endpackage

/* rtl/rvdi_decode.sv */
// ----------------------------------------------------------------------------
// RV32I decode and immediate unit: opcode decoder
// Turns an instruction word into register indices and control fields.
// ----------------------------------------------------------------------------
module rvdi_decode
   import rvdi_pkg::*;
(
   input  logic [XLEN-1:0] instruction,
   output ctrl_type        ctrl
);

   opcode_type   opcode;
   logic [2:0]   f3;
   logic         bit30;
   alu_func_type alu_reg;
   alu_func_type alu_imm;

   assign opcode = instruction[6:0];
   assign f3     = instruction[14:12];
   assign bit30  = instruction[30];

   // Register form uses bit 30 to pick sub or sra; immediate form uses it only for sra.
   always_comb begin
      unique case (f3)
         3'd0:    alu_reg = bit30 ? ALU_SUB : ALU_ADD;
         3'd1:    alu_reg = ALU_SLL;
         3'd2:    alu_reg = ALU_SLT;
         3'd3:    alu_reg = ALU_SLTU;
         3'd4:    alu_reg = ALU_XOR;
         3'd5:    alu_reg = bit30 ? ALU_SRA : ALU_SRL;
         3'd6:    alu_reg = ALU_OR;
         default: alu_reg = ALU_AND;
      endcase
   end

   assign alu_imm = (f3 == 3'd0) ? ALU_ADD : alu_reg;

   always_comb begin
      ctrl             = '0;
      ctrl.func3_field = f3;
      unique case (opcode)
         OPC_LOAD: begin
            ctrl.src1_index      = instruction[19:15];
            ctrl.dest_index      = instruction[11:7];
            ctrl.is_load         = 1'b1;
            ctrl.writes_register = 1'b1;
            ctrl.uses_immediate  = 1'b1;
            ctrl.alu_function    = ALU_ADD;
            ctrl.imm_sel         = IMM_I;
         end
         OPC_STORE: begin
            ctrl.src1_index     = instruction[19:15];
            ctrl.src2_index     = instruction[24:20];
            ctrl.is_store       = 1'b1;
            ctrl.uses_immediate = 1'b1;
            ctrl.alu_function   = ALU_ADD;
            ctrl.imm_sel        = IMM_S;
         end
         OPC_OP: begin
            ctrl.src1_index      = instruction[19:15];
            ctrl.src2_index      = instruction[24:20];
            ctrl.dest_index      = instruction[11:7];
            ctrl.writes_register = 1'b1;
            ctrl.alu_function    = alu_reg;
         end
         OPC_OPIMM: begin
            ctrl.src1_index      = instruction[19:15];
            ctrl.dest_index      = instruction[11:7];
            ctrl.writes_register = 1'b1;
            ctrl.uses_immediate  = 1'b1;
            ctrl.alu_function    = alu_imm;
            ctrl.imm_sel         = IMM_I;
         end
         OPC_BRANCH: begin
            ctrl.src1_index   = instruction[19:15];
            ctrl.src2_index   = instruction[24:20];
            ctrl.alu_function = ALU_SUB;
            ctrl.imm_sel      = IMM_B;
            ctrl.pc_relative  = 1'b1;
            unique case (f3)
               3'd0:    ctrl.branch_kind = BR_BEQ;
               3'd1:    ctrl.branch_kind = BR_BNE;
               3'd4:    ctrl.branch_kind = BR_BLT;
               3'd5:    ctrl.branch_kind = BR_BGE;
               3'd6:    ctrl.branch_kind = BR_BLTU;
               3'd7:    ctrl.branch_kind = BR_BGEU;
               default: ctrl.branch_kind = BR_NONE;
            endcase
         end
         OPC_JAL: begin
            ctrl.dest_index      = instruction[11:7];
            ctrl.writes_register = 1'b1;
            ctrl.uses_immediate  = 1'b1;
            ctrl.alu_function    = ALU_ADD;
            ctrl.imm_sel         = IMM_J;
            ctrl.pc_relative     = 1'b1;
         end
         OPC_JALR: begin
            ctrl.src1_index      = instruction[19:15];
            ctrl.dest_index      = instruction[11:7];
            ctrl.writes_register = 1'b1;
            ctrl.uses_immediate  = 1'b1;
            ctrl.alu_function    = ALU_ADD;
            ctrl.imm_sel         = IMM_I;
         end
         OPC_LUI: begin
            ctrl.dest_index      = instruction[11:7];
            ctrl.func3_field     = 3'd0;
            ctrl.writes_register = 1'b1;
            ctrl.uses_immediate  = 1'b1;
            ctrl.alu_function    = ALU_PASS;
            ctrl.imm_sel         = IMM_U;
         end
         OPC_AUIPC: begin
            ctrl.dest_index      = instruction[11:7];
            ctrl.func3_field     = 3'd0;
            ctrl.writes_register = 1'b1;
            ctrl.uses_immediate  = 1'b1;
            ctrl.alu_function    = ALU_ADD;
            ctrl.imm_sel         = IMM_U;
         end
         default: begin
            // Unknown opcode: only funct3 passes through.
            ctrl.func3_field = f3;
         end
      endcase
   end

endmodule

/* rtl/rvdi_imm_gen.sv */
// ----------------------------------------------------------------------------
// RV32I decode and immediate unit: immediate generator
// Builds the format immediate and the pc-relative target.
// ----------------------------------------------------------------------------
module rvdi_imm_gen
   import rvdi_pkg::*;
(
   input  logic [XLEN-1:0] instruction,
   input  logic [XLEN-1:0] fetch_pc,
   input  imm_sel_type     imm_sel,
   input  logic            pc_relative,
   output logic [XLEN-1:0] immediate,
   output logic [XLEN-1:0] branch_target
);

   logic sign;

   assign sign = instruction[31];

   always_comb begin
      unique case (imm_sel)
         IMM_I:   immediate = {{20{sign}}, instruction[31:20]};
         IMM_S:   immediate = {{20{sign}}, instruction[31:25], instruction[11:7]};
         IMM_B:   immediate = {{20{sign}}, instruction[7], instruction[30:25],
                               instruction[11:8], 1'b0};
         IMM_J:   immediate = {{12{sign}}, instruction[19:12], instruction[20],
                               instruction[30:21], 1'b0};
         IMM_U:   immediate = {instruction[31:12], 12'h000};
         default: immediate = '0;
      endcase
   end

   // The sum wraps modulo 2^32.
   assign branch_target = pc_relative ? (fetch_pc + immediate) : '0;

endmodule

/* rtl/rv32i_decode_and_immediate_unit.sv */
// ----------------------------------------------------------------------------
// RV32I decode and immediate unit
// Decodes one RV32I instruction word per item into controls and immediates.
// ----------------------------------------------------------------------------
// The req channel carries one item per instruction: the instruction word and
// the address it was fetched from. The rsp channel returns one decoded item
// for each, in order: register indices, funct3, branch kind, the load,
// store, register-write and uses-immediate controls, the ALU function,
// the sign-extended immediate and the branch or jal target.
// An accepted item sits in an input register while the decoder and the
// immediate/target adder work on it, and the result is captured in an
// output register. While the receiver takes results, throughput is one
// item per cycle, because each register takes a new item in the same
// cycle that it hands its current item on.
// When the receiver stalls, the output register holds its item and the
// input register can still take one more; only when both are full does
// req_tready drop. Reset empties both registers, so rsp_tvalid is low and
// req_tready is high in the first cycle after reset.
// ----------------------------------------------------------------------------
`include "rv32i_decode_and_immediate_unit_defines.svh"

module rv32i_decode_and_immediate_unit
   import rvdi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] instruction, [63:32] fetch_pc
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [4:0] src1_index, [9:5] src2_index, [14:10] dest_index,
   // [17:15] func3_field, [20:18] branch_kind, [21] is_load, [22] is_store,
   // [23] writes_register, [24] uses_immediate, [28:25] alu_function,
   // [60:29] immediate, [92:61] branch_target, [95:93] zero
   output logic [95:0] rsp_tdata
);

   // Input register stage.
   logic            in_valid_ff;
   logic            in_valid_in;
   logic [XLEN-1:0] in_instr_ff;
   logic [XLEN-1:0] in_pc_ff;

   // Output register stage.
   logic            out_valid_ff;
   logic            out_valid_in;
   result_type      out_res_ff;
   result_type      out_res_in;

   logic            out_ready;
   logic            in_ready;
   logic            req_fire;
   logic            advance;

   ctrl_type        ctrl;
   logic [XLEN-1:0] immediate;
   logic [XLEN-1:0] branch_target;

   // Each stage takes a new item when it is empty or drains in this cycle.
   assign out_ready  = !out_valid_ff || rsp_tready;
   assign in_ready   = !in_valid_ff || out_ready;
   assign req_tready = in_ready;
   assign req_fire   = req_tvalid && in_ready;
   assign advance    = in_valid_ff && out_ready;

   rvdi_decode u_decode (
      .instruction (in_instr_ff),
      .ctrl        (ctrl)
   );

   rvdi_imm_gen u_imm_gen (
      .instruction   (in_instr_ff),
      .fetch_pc      (in_pc_ff),
      .imm_sel       (ctrl.imm_sel),
      .pc_relative   (ctrl.pc_relative),
      .immediate     (immediate),
      .branch_target (branch_target)
   );

   always_comb begin
      out_res_in.src1_index      = ctrl.src1_index;
      out_res_in.src2_index      = ctrl.src2_index;
      out_res_in.dest_index      = ctrl.dest_index;
      out_res_in.func3_field     = ctrl.func3_field;
      out_res_in.branch_kind     = ctrl.branch_kind;
      out_res_in.is_load         = ctrl.is_load;
      out_res_in.is_store        = ctrl.is_store;
      out_res_in.writes_register = ctrl.writes_register;
      out_res_in.uses_immediate  = ctrl.uses_immediate;
      out_res_in.alu_function    = ctrl.alu_function;
      out_res_in.immediate       = immediate;
      out_res_in.branch_target   = branch_target;
   end

   // The input stage is full next when it holds an item that cannot move on,
   // or when it accepts a new item, also one that replaces the item moving on.
   assign in_valid_in  = req_fire || (in_valid_ff && !out_ready);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_instr_ff <= req_tdata[31:0];
         in_pc_ff    <= req_tdata[63:32];
      end
      if (advance) begin
         out_res_ff <= out_res_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;

   assign rsp_tdata = {3'b000,
                       out_res_ff.branch_target,
                       out_res_ff.immediate,
                       out_res_ff.alu_function,
                       out_res_ff.uses_immediate,
                       out_res_ff.writes_register,
                       out_res_ff.is_store,
                       out_res_ff.is_load,
                       out_res_ff.branch_kind,
                       out_res_ff.func3_field,
                       out_res_ff.dest_index,
                       out_res_ff.src2_index,
                       out_res_ff.src1_index};

   // With the output stage empty, the unit must always be able to take an item.
   `RVDI_ASSERT_IMPLIES(a_ready_when_drained, clock, reset,
      !out_valid_ff, req_tready, "unit stalls with empty output stage")

   // A result never marks both a load and a store.
   `RVDI_ASSERT_NEVER(a_load_store_exclusive, clock, reset,
      out_valid_ff && out_res_ff.is_load && out_res_ff.is_store, "load and store both set")

   // Stores and branches never write the register file.
   `RVDI_ASSERT_NEVER(a_no_write_on_store_branch, clock, reset,
      out_valid_ff && out_res_ff.writes_register &&
      (out_res_ff.is_store || out_res_ff.branch_kind != BR_NONE),
      "register write on store or branch")

   // Loads take the immediate as the address offset and add it.
   `RVDI_ASSERT_IMPLIES(a_load_uses_add, clock, reset,
      out_valid_ff && out_res_ff.is_load,
      out_res_ff.uses_immediate && out_res_ff.alu_function == ALU_ADD,
      "load decoded without immediate add")

endmodule
